/* rtl/mdstg_pkg.sv */
// shared types and constants of the multi-drive step tone generator
// used by mdstg_drive and multi_drive_step_tone_generator_top; no dependencies
package mdstg_pkg;

  localparam int REQ_W          = 2;
  localparam int DRIVE_IDX_W    = 3;
  localparam int PERIOD_FIELD_W = 16;
  localparam int POS_W          = 8;
  localparam int LEVELS_W       = 8;

  // tdata widths, padded up to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [POS_W-1:0] POS_LIMIT_RST = 8'd158;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK       = 2'd0,
    REQ_SET_PERIOD = 2'd1,
    REQ_CLEAR_ALL  = 2'd2,
    REQ_NONE       = 2'd3
  } req_t;

  // one decoded request, valid only in the cycle the item is processed
  typedef struct packed {
    logic tick;
    logic set_period;
    logic clear_all;
  } drive_cmd_t;

endpackage

/* rtl/multi_drive_step_tone_generator_top.sv */
// top level of the multi-drive step tone generator: input register, drive array,
// result register and the position limit register; depends on mdstg_pkg, mdstg_drive
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | slave     | in_tvalid/in_tready | tuser req_type, tdata drive, period
//  out_    | master    | out_tvalid/tready   | tdata step, direction, stepped masks
//  cfg_    | slave     | cfg_tvalid/tready   | tdata position limit
//
// one transaction per cycle in steady state while out_tready is high; an input passes
// through the input register, then through the drive update into the result register.
// rst_n is synchronous: all drives stop at position zero, the position limit returns to 158.
// a stalled result holds while one more input waits in the input register;
// in_tready drops only when both registers are full and out_tready is low.
module multi_drive_step_tone_generator_top #(
  parameter int DRIVES      = 8,
  parameter int PERIOD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mdstg_pkg::IN_DATA_W-1:0]     in_tdata,   // drive[2:0], period[18:3], zeros
  input  logic [mdstg_pkg::REQ_W-1:0]         in_tuser,   // req_type[1:0]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mdstg_pkg::OUT_DATA_W-1:0]    out_tdata,  // step[7:0], direction[15:8],
                                                          // stepped[23:16]
  input  logic                                cfg_tvalid,
  output logic                                cfg_tready,
  input  logic [mdstg_pkg::POS_W-1:0]         cfg_tdata   // position limit[7:0]
);

  localparam int PF = mdstg_pkg::PERIOD_FIELD_W;
  localparam int DI = mdstg_pkg::DRIVE_IDX_W;

  logic                                in_valid_r;
  mdstg_pkg::req_t                     req_r;
  logic [DI-1:0]                       drive_r;
  logic [PF-1:0]                       period_r;
  logic                                out_valid_r;
  logic [mdstg_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [mdstg_pkg::POS_W-1:0]         pos_limit_r;
  logic                                fire;
  mdstg_pkg::drive_cmd_t               cmd;
  logic [PERIOD_BITS-1:0]              period_w;
  logic [DRIVES-1:0]                   pins, dirs, steps;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r    <= mdstg_pkg::req_t'(in_tuser);
      drive_r  <= in_tdata[DI-1:0];
      period_r <= in_tdata[DI+PF-1:DI];
    end
  end

  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_limit_r <= mdstg_pkg::POS_LIMIT_RST;
    end else if (cfg_tvalid) begin
      pos_limit_r <= cfg_tdata;
    end
  end

  always_comb begin
    cmd = '0;
    if (fire) begin
      case (req_r)
        mdstg_pkg::REQ_TICK:       cmd.tick       = 1'b1;
        mdstg_pkg::REQ_SET_PERIOD: cmd.set_period = 1'b1;
        mdstg_pkg::REQ_CLEAR_ALL:  cmd.clear_all  = 1'b1;
        default:                   cmd            = '0;
      endcase
    end
  end

  // fit the 16-bit period field to the counter width
  generate
    if (PERIOD_BITS > PF) begin : g_per_wide
      assign period_w = {{(PERIOD_BITS-PF){1'b0}}, period_r};
    end else if (PERIOD_BITS == PF) begin : g_per_same
      assign period_w = period_r;
    end else begin : g_per_narrow
      assign period_w = period_r[PERIOD_BITS-1:0];
    end
  endgenerate

  generate
    for (genvar g = 0; g < DRIVES; g++) begin : g_drive
      mdstg_drive #(
        .PERIOD_BITS (PERIOD_BITS)
      ) u_drive (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sel          (drive_r == DI'(g)),
        .period       (period_w),
        .pos_limit    (pos_limit_r),
        .pin_nxt      (pins[g]),
        .dir_nxt      (dirs[g]),
        .stepped      (steps[g])
      );
    end
  endgenerate

  assign out_data_nxt = {mdstg_pkg::LEVELS_W'(steps),
                         mdstg_pkg::LEVELS_W'(dirs),
                         mdstg_pkg::LEVELS_W'(pins)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* rtl/mdstg_drive.sv */
// one drive channel: period, tick counter, head position, direction and step level
// depends on mdstg_pkg for the command struct and position width
module mdstg_drive #(
  parameter int PERIOD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mdstg_pkg::drive_cmd_t         cmd,
  input  logic                          sel,
  input  logic [PERIOD_BITS-1:0]        period,
  input  logic [mdstg_pkg::POS_W-1:0]   pos_limit,
  output logic                          pin_nxt,
  output logic                          dir_nxt,
  output logic                          stepped
);

  logic [PERIOD_BITS-1:0]        period_r, period_nxt;
  logic [PERIOD_BITS-1:0]        count_r, count_nxt;
  logic [mdstg_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                          back_r;
  logic                          level_r, level_nxt;
  logic                          pin_r;
  logic [PERIOD_BITS-1:0]        count_inc;
  logic                          turn_back;

  assign count_inc = count_r + 1'b1;

  always_comb begin
    period_nxt = period_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    dir_nxt    = back_r;
    level_nxt  = level_r;
    pin_nxt    = pin_r;
    stepped    = 1'b0;
    turn_back  = back_r;

    if (cmd.tick && (period_r != '0)) begin
      if (count_inc >= period_r) begin
        stepped   = 1'b1;
        count_nxt = '0;
        // reverse at the limit, go forward again at zero
        if (pos_r >= pos_limit) begin
          turn_back = 1'b1;
        end else if (pos_r == '0) begin
          turn_back = 1'b0;
        end
        dir_nxt   = turn_back;
        pos_nxt   = turn_back ? pos_r - 1'b1 : pos_r + 1'b1;
        pin_nxt   = level_r;
        level_nxt = ~level_r;
      end else begin
        count_nxt = count_inc;
      end
    end

    if (cmd.set_period && sel) begin
      period_nxt = period;
    end

    // tick count and step level survive a clear of all drives
    if (cmd.clear_all) begin
      period_nxt = '0;
      pos_nxt    = '0;
      dir_nxt    = 1'b0;
      pin_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      count_r  <= '0;
      pos_r    <= '0;
      back_r   <= 1'b0;
      level_r  <= 1'b0;
      pin_r    <= 1'b0;
    end else begin
      period_r <= period_nxt;
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
      back_r   <= dir_nxt;
      level_r  <= level_nxt;
      pin_r    <= pin_nxt;
    end
  end

endmodule
